// ===== src/ordered_int_key_value_table_macros.svh =====
// Assertion macros shared by the table RTL
`ifndef ORDERED_INT_KEY_VALUE_TABLE_MACROS_SVH
`define ORDERED_INT_KEY_VALUE_TABLE_MACROS_SVH

// a implies b in the same cycle, checked outside reset
`define OIKV_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("oikv assertion failed");

// a implies b in the next cycle, checked outside reset
`define OIKV_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("oikv assertion failed");

`endif

// ===== src/oikv_pkg.sv =====
// Package: sizes, opcodes and cell control type for the key/value table
package oikv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_DEL = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  // per-cell command for the cycle an item is accepted
  typedef struct packed {
    logic       accept;
    logic [1:0] opcode;
    logic       used;     // cell holds a live entry
    logic       tail;     // first free cell, append target
    logic       any_hit;  // key matched somewhere in the row
  } cell_cmd_t;

endpackage

// ===== src/ordered_int_key_value_table.sv =====
// Ordered key/value table: a row of cells searched in parallel, one item per cycle
// unless replies stall. On each accepted request (set, get or delete) every cell
// compares its key at once, the hit ripples up the cell row so that on delete every
// later cell takes its upper neighbor's entry, and the result is registered and
// shows in the cycle after acceptance. A new item is taken every cycle while the
// result register is empty or being drained, so the sustained rate is one item per
// clock. The search compare and the hit ripple through the cell row set the clock period.
`include "ordered_int_key_value_table_macros.svh"

module ordered_int_key_value_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         opcode,
  input  logic signed [oikv_pkg::KEY_W-1:0]  key,
  input  logic signed [oikv_pkg::VAL_W-1:0]  new_value,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic                               found,
  output logic signed [oikv_pkg::VAL_W-1:0]  read_value,
  output logic                               table_full,
  output logic [oikv_pkg::OUT_CNT_W-1:0]     entry_count
);

  localparam int N = oikv_pkg::ENTRIES;

  logic                        accept;
  logic [oikv_pkg::CNT_W-1:0]  count;
  logic [oikv_pkg::CNT_W-1:0]  count_next;
  logic [N:0]                  hit_chain;
  logic [N-1:0]                match_vec;
  logic [oikv_pkg::KEY_W-1:0]  cell_key   [N];
  logic [oikv_pkg::VAL_W-1:0]  cell_value [N];
  logic                        any_hit;
  logic                        is_full;
  logic                        full_drop;
  logic [oikv_pkg::VAL_W-1:0]  hit_value;
  logic [oikv_pkg::VAL_W-1:0]  rd_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign hit_chain[0] = 1'b0;
  assign any_hit   = hit_chain[N];
  assign is_full   = (count == oikv_pkg::CNT_W'(N));

  for (genvar i = 0; i < N; i++) begin : g_cell
    oikv_pkg::cell_cmd_t cmd;
    logic [oikv_pkg::KEY_W-1:0] up_k;
    logic [oikv_pkg::VAL_W-1:0] up_v;

    assign cmd.accept  = accept;
    assign cmd.opcode  = opcode;
    assign cmd.used    = oikv_pkg::CNT_W'(i) < count;
    assign cmd.tail    = oikv_pkg::CNT_W'(i) == count;
    assign cmd.any_hit = any_hit;

    if (i == N - 1) begin : g_top
      assign up_k = cell_key[i];
      assign up_v = cell_value[i];
    end else begin : g_mid
      assign up_k = cell_key[i+1];
      assign up_v = cell_value[i+1];
    end

    oikv_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .req_key    (key),
      .req_value  (new_value),
      .up_key     (up_k),
      .up_value   (up_v),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .match      (match_vec[i]),
      .cell_key   (cell_key[i]),
      .cell_value (cell_value[i])
    );
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      hit_value = hit_value | (cell_value[i] & {oikv_pkg::VAL_W{match_vec[i]}});
    end
  end

  always_comb begin
    count_next = count;
    full_drop  = 1'b0;
    rd_next    = '1;
    case (opcode)
      oikv_pkg::OP_SET: begin
        if (!any_hit) begin
          if (is_full) begin
            full_drop = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      oikv_pkg::OP_GET: begin
        if (any_hit) begin
          rd_next = hit_value;
        end
      end
      oikv_pkg::OP_DEL: begin
        if (any_hit) begin
          count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found       <= any_hit && (opcode != oikv_pkg::OP_NOP);
      read_value  <= rd_next;
      table_full  <= full_drop;
      entry_count <= count_next[oikv_pkg::OUT_CNT_W-1:0];
    end
  end

  `OIKV_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= oikv_pkg::CNT_W'(N))
  `OIKV_ASSERT_IMP(a_keys_unique, clk, rst, 1'b1, $onehot0(match_vec))
  `OIKV_ASSERT_NEXT(a_rsp_after_accept, clk, rst, accept, rsp_valid)
  `OIKV_ASSERT_IMP(a_full_not_found, clk, rst, rsp_valid && table_full, !found)

endmodule

// ===== src/oikv_cell.sv =====
// One table cell: holds a key/value pair, compares, updates, shifts from neighbor
module oikv_cell (
  input  logic                        clk,
  input  oikv_pkg::cell_cmd_t         cmd,
  input  logic [oikv_pkg::KEY_W-1:0]  req_key,
  input  logic [oikv_pkg::VAL_W-1:0]  req_value,
  input  logic [oikv_pkg::KEY_W-1:0]  up_key,
  input  logic [oikv_pkg::VAL_W-1:0]  up_value,
  input  logic                        hit_in,
  output logic                        hit_out,
  output logic                        match,
  output logic [oikv_pkg::KEY_W-1:0]  cell_key,
  output logic [oikv_pkg::VAL_W-1:0]  cell_value
);

  logic [oikv_pkg::KEY_W-1:0] key_q;
  logic [oikv_pkg::VAL_W-1:0] value_q;
  logic [oikv_pkg::KEY_W-1:0] key_next;
  logic [oikv_pkg::VAL_W-1:0] value_next;

  assign match      = cmd.used && (key_q == req_key);
  assign hit_out    = hit_in | match;
  assign cell_key   = key_q;
  assign cell_value = value_q;

  always_comb begin
    key_next   = key_q;
    value_next = value_q;
    if (cmd.accept) begin
      case (cmd.opcode)
        oikv_pkg::OP_SET: begin
          if (match) begin
            value_next = req_value;
          end else if (cmd.tail && !cmd.any_hit) begin
            key_next   = req_key;
            value_next = req_value;
          end
        end
        oikv_pkg::OP_DEL: begin
          // cells at or above the deleted one take their upper neighbor
          if (hit_out) begin
            key_next   = up_key;
            value_next = up_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_q   <= key_next;
    value_q <= value_next;
  end

endmodule

// ===== test/ordered_int_key_value_table_tb.sv =====
// Testbench for the ordered key/value table: tracker class, request and reply drivers, watchdog
`timescale 1ns / 100ps

module ordered_int_key_value_table_tb;

  localparam logic [oikv_pkg::VAL_W-1:0] NO_VALUE       = '1;
  localparam int                         WATCHDOG_LIMIT = 4000;
  localparam int                         POOL_SIZE      = 24;
  localparam int                         HOLD_CYCLES    = 300;

  typedef struct packed {
    logic                           found;
    logic [oikv_pkg::VAL_W-1:0]     read_value;
    logic                           table_full;
    logic [oikv_pkg::OUT_CNT_W-1:0] entry_count;
  } table_reply_t;

  // Tracks table contents and the replies still owed by the block
  class kv_table_tracker;
    logic [oikv_pkg::KEY_W-1:0] keys[oikv_pkg::ENTRIES];
    logic [oikv_pkg::VAL_W-1:0] vals[oikv_pkg::ENTRIES];
    int                         used;
    table_reply_t               expected_replies[$];
    int                         errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    function void note_request(logic [1:0] op, logic [oikv_pkg::KEY_W-1:0] k,
                               logic [oikv_pkg::VAL_W-1:0] v);
      table_reply_t r;
      int           pos;
      r.found      = 1'b0;
      r.read_value = NO_VALUE;
      r.table_full = 1'b0;
      pos          = -1;
      if (op != oikv_pkg::OP_NOP) begin
        for (int i = 0; i < used; i++)
          if (pos < 0 && keys[i] == k) pos = i;
        r.found = (pos >= 0);
      end
      case (op)
        oikv_pkg::OP_SET: begin
          if (pos >= 0) begin
            vals[pos] = v;
          end else if (used < oikv_pkg::ENTRIES) begin
            keys[used] = k;
            vals[used] = v;
            used++;
          end else begin
            r.table_full = 1'b1;
          end
        end
        oikv_pkg::OP_GET: begin
          if (pos >= 0) r.read_value = vals[pos];
        end
        oikv_pkg::OP_DEL: begin
          // later entries slide down one place to keep insertion order
          if (pos >= 0) begin
            for (int i = pos; i < used - 1; i++) begin
              keys[i] = keys[i + 1];
              vals[i] = vals[i + 1];
            end
            used--;
          end
        end
        default: ;
      endcase
      r.entry_count = used[oikv_pkg::OUT_CNT_W-1:0];
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic f, logic [oikv_pkg::VAL_W-1:0] rv, logic tf,
                              logic [oikv_pkg::OUT_CNT_W-1:0] cnt);
      table_reply_t e;
      if (expected_replies.size() == 0) begin
        $error("reply with no request outstanding");
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      if (f !== e.found) begin
        $error("found: expected %0b, got %0b", e.found, f);
        errors++;
      end
      if (rv !== e.read_value) begin
        $error("read_value: expected %0d, got %0d",
               $signed(e.read_value), $signed(rv));
        errors++;
      end
      if (tf !== e.table_full) begin
        $error("table_full: expected %0b, got %0b", e.table_full, tf);
        errors++;
      end
      if (cnt !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              req_valid = 1'b0;
  logic                              req_stall;
  logic [1:0]                        opcode = oikv_pkg::OP_SET;
  logic signed [oikv_pkg::KEY_W-1:0] key = '0;
  logic signed [oikv_pkg::VAL_W-1:0] new_value = '0;
  logic                              rsp_valid;
  logic                              rsp_stall = 1'b0;
  logic                              found;
  logic signed [oikv_pkg::VAL_W-1:0] read_value;
  logic                              table_full;
  logic [oikv_pkg::OUT_CNT_W-1:0]    entry_count;

  kv_table_tracker            tracker;
  int                         sender_idle_pct = 0;
  int                         rsp_stall_pct = 0;
  int                         hold_left = 0;
  int                         quiet_cycles = 0;
  logic [oikv_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  ordered_int_key_value_table dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .opcode      (opcode),
    .key         (key),
    .new_value   (new_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .found       (found),
    .read_value  (read_value),
    .table_full  (table_full),
    .entry_count (entry_count)
  );

  always #2 clk = ~clk;

  // Reply side: check accepted replies, then pick next cycle's stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall)
        tracker.check_reply(found, read_value, table_full, entry_count);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [oikv_pkg::KEY_W-1:0] k,
                           input logic [oikv_pkg::VAL_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode    <= op;
    key       <= k;
    new_value <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_request(op, k, v);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Small key pool so that hits, deletes and a full table are common
  task automatic refill_keys();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
  endtask

  task automatic send_random(input int count);
    int                         set_w;
    int                         r;
    logic [1:0]                 op;
    logic [oikv_pkg::KEY_W-1:0] k;
    set_w = 50;
    for (int i = 0; i < count; i++) begin
      // mix drifts between filling and draining the table
      if (i % 40 == 0) set_w = $urandom_range(25, 70);
      r = $urandom_range(99);
      if (r < set_w) op = oikv_pkg::OP_SET;
      else if (r < set_w + (95 - set_w) / 2) op = oikv_pkg::OP_GET;
      else if (r < 95) op = oikv_pkg::OP_DEL;
      else op = oikv_pkg::OP_NOP;
      k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1)];
      send_item(op, k, $urandom);
    end
  endtask

  initial begin
    tracker = new();
    refill_keys();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every opcode, full table, absent deletes
    send_item(oikv_pkg::OP_SET, 32'h8000_0000, 32'h7fff_ffff);
    send_item(oikv_pkg::OP_SET, 32'h7fff_ffff, 32'h8000_0000);
    send_item(oikv_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000);
    send_item(oikv_pkg::OP_SET, 32'hffff_ffff, 32'hffff_ffff);
    send_item(oikv_pkg::OP_GET, 32'h8000_0000, 32'h1234_5678);
    send_item(oikv_pkg::OP_GET, 32'h7fff_ffff, 32'h0);
    send_item(oikv_pkg::OP_GET, 32'h5555_aaaa, 32'h0);
    send_item(oikv_pkg::OP_SET, 32'h8000_0000, 32'h0bad_cafe);
    send_item(oikv_pkg::OP_DEL, 32'h5555_aaaa, 32'h0);
    send_item(oikv_pkg::OP_NOP, 32'h0000_0000, 32'hffff_ffff);
    send_item(oikv_pkg::OP_DEL, 32'h7fff_ffff, 32'h0);
    send_item(oikv_pkg::OP_GET, 32'h0000_0000, 32'h0);
    for (int i = 0; i < oikv_pkg::ENTRIES - 3; i++)
      send_item(oikv_pkg::OP_SET, 32'h0100_0000 + i * 32'h0011_0101, $urandom);
    send_item(oikv_pkg::OP_SET, 32'haaaa_5555, 32'h1111_1111);
    send_item(oikv_pkg::OP_SET, 32'h8000_0000, 32'h2222_2222);
    send_item(oikv_pkg::OP_GET, 32'h8000_0000, 32'h0);
    send_item(oikv_pkg::OP_DEL, 32'h8000_0000, 32'h0);
    send_item(oikv_pkg::OP_DEL,
              32'h0100_0000 + (oikv_pkg::ENTRIES - 4) * 32'h0011_0101, 32'h0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; rsp_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rsp_stall_pct = 69; end
        default: begin sender_idle_pct = 18; rsp_stall_pct = 18; end
      endcase
      refill_keys();
      send_random(190);
      wait_drained();
    end

    // receiver holds off while requests keep coming, so the input backs up
    sender_idle_pct = 0;
    rsp_stall_pct   = 0;
    hold_left       = HOLD_CYCLES;
    send_random(80);
    wait_drained();

    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
